[design/bal_pkg.sv]
// Shared types, codes and constants for the bounded array list.
package bal_pkg;

  localparam int CW            = 7;
  localparam int VW            = 32;
  localparam int DEFAULT_DEPTH = 64;

  typedef logic [CW-1:0]        count_t;
  typedef logic signed [VW-1:0] value_t;

  localparam count_t CAPACITY_RESET = count_t'(64);
  localparam value_t FILL_RESET     = '0;
  localparam value_t RD_INVALID     = -32'sd1;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_REMOVE,
    OP_READ,
    OP_CLEAR
  } op_t;

  typedef enum logic [1:0] {
    STS_OK,
    STS_BAD_POS,
    STS_FULL,
    STS_EMPTY
  } status_t;

  typedef enum logic [0:0] {
    CFG_CAPACITY,
    CFG_FILL
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_INS_PUT,
    S_REM_RD,
    S_REM_WR,
    S_REM_TAIL,
    S_READ_WAIT,
    S_CLEAR,
    S_RESP
  } seq_state_t;

  typedef struct packed {
    op_t    operation;
    count_t position;
    value_t item_value;
  } req_t;

  typedef struct packed {
    status_t status;
    value_t  read_value;
    count_t  entry_count;
    logic    is_full;
    logic    is_empty;
  } rsp_t;

endpackage

[design/bal_chan_if.sv]
// Valid/ready channel carrying one payload item per transfer.
interface bal_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/bal_slot_ram.sv]
// Slot store: one write port, one read port with registered read data.
module bal_slot_ram #(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic signed [31:0]       wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic signed [31:0]       rdata
);
  logic signed [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[design/bal_seq.sv]
// Sequencer: walks a shared slot index to shift, fill and read the slot store.
module bal_seq #(
  parameter int DEPTH = bal_pkg::DEFAULT_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_ready,
  input  bal_pkg::req_t            req_data,
  input  bal_pkg::count_t          cap,
  input  bal_pkg::value_t          fill,
  output logic                     rsp_valid,
  input  logic                     rsp_take,
  output bal_pkg::rsp_t            rsp_data,
  output logic                     mem_we,
  output logic [$clog2(DEPTH)-1:0] mem_waddr,
  output bal_pkg::value_t          mem_wdata,
  output logic [$clog2(DEPTH)-1:0] mem_raddr,
  input  bal_pkg::value_t          mem_rdata
);
  import bal_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int IW = (AW > CW) ? AW : CW;
  localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

  seq_state_t    state, state_next;
  count_t        pos, pos_next;
  value_t        val, val_next;
  logic [IW-1:0] idx, idx_next;
  count_t        cnt, cnt_next;
  status_t       status, status_next;
  value_t        rd, rd_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      idx   <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    pos    <= pos_next;
    val    <= val_next;
    status <= status_next;
    rd     <= rd_next;
  end

  always_comb begin
    state_next  = state;
    pos_next    = pos;
    val_next    = val;
    idx_next    = idx;
    cnt_next    = cnt;
    status_next = status;
    rd_next     = rd;
    req_ready   = 1'b0;
    rsp_valid   = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = AW'(idx);
    mem_wdata   = mem_rdata;
    mem_raddr   = AW'(idx);

    unique case (state)
      S_INIT: begin
        // post-reset sweep: every slot to the reset fill value
        mem_we    = 1'b1;
        mem_wdata = FILL_RESET;
        if (idx == LAST) begin
          idx_next   = '0;
          state_next = S_IDLE;
        end else begin
          idx_next = idx + IW'(1);
        end
      end
      S_IDLE: begin
        req_ready = 1'b1;
        mem_raddr = AW'(req_data.position);
        if (req_valid) begin
          pos_next    = req_data.position;
          val_next    = req_data.item_value;
          status_next = STS_OK;
          rd_next     = '0;
          unique case (req_data.operation)
            OP_INSERT: begin
              priority if (req_data.position > cnt) begin
                status_next = STS_BAD_POS;
                state_next  = S_RESP;
              end else if (cnt >= cap) begin
                status_next = STS_FULL;
                state_next  = S_RESP;
              end else begin
                idx_next   = IW'(cnt);
                state_next = (req_data.position == cnt) ? S_INS_PUT : S_INS_RD;
              end
            end
            OP_REMOVE: begin
              priority if (cnt == '0) begin
                status_next = STS_EMPTY;
                state_next  = S_RESP;
              end else if (req_data.position >= cnt) begin
                status_next = STS_BAD_POS;
                state_next  = S_RESP;
              end else begin
                idx_next   = IW'(req_data.position);
                state_next = (IW'(req_data.position) + IW'(1) < IW'(cnt)) ?
                             S_REM_RD : S_REM_TAIL;
              end
            end
            OP_READ: begin
              if (req_data.position >= cap) begin
                status_next = STS_BAD_POS;
                rd_next     = RD_INVALID;
                state_next  = S_RESP;
              end else begin
                state_next = S_READ_WAIT;
              end
            end
            OP_CLEAR: begin
              cnt_next   = '0;
              idx_next   = '0;
              state_next = S_CLEAR;
            end
          endcase
        end
      end
      S_INS_RD: begin
        mem_raddr  = AW'(idx - IW'(1));
        state_next = S_INS_WR;
      end
      S_INS_WR: begin
        // move the entry below up by one slot
        mem_we     = 1'b1;
        idx_next   = idx - IW'(1);
        state_next = (idx - IW'(1) == IW'(pos)) ? S_INS_PUT : S_INS_RD;
      end
      S_INS_PUT: begin
        mem_we     = 1'b1;
        mem_waddr  = AW'(pos);
        mem_wdata  = val;
        cnt_next   = cnt + count_t'(1);
        state_next = S_RESP;
      end
      S_REM_RD: begin
        mem_raddr  = AW'(idx + IW'(1));
        state_next = S_REM_WR;
      end
      S_REM_WR: begin
        // move the entry above down by one slot
        mem_we     = 1'b1;
        idx_next   = idx + IW'(1);
        state_next = (idx + IW'(2) < IW'(cnt)) ? S_REM_RD : S_REM_TAIL;
      end
      S_REM_TAIL: begin
        mem_we     = 1'b1;
        mem_waddr  = AW'(cnt - count_t'(1));
        mem_wdata  = fill;
        cnt_next   = cnt - count_t'(1);
        state_next = S_RESP;
      end
      S_READ_WAIT: begin
        rd_next    = mem_rdata;
        state_next = S_RESP;
      end
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = fill;
        if (idx == LAST) begin
          idx_next   = '0;
          state_next = S_RESP;
        end else begin
          idx_next = idx + IW'(1);
        end
      end
      S_RESP: begin
        // hold until the output register is free
        rsp_valid = 1'b1;
        if (rsp_take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  always_comb begin
    rsp_data.status      = status;
    rsp_data.read_value  = rd;
    rsp_data.entry_count = cnt;
    rsp_data.is_full     = (cnt >= cap);
    rsp_data.is_empty    = (cnt == '0);
  end

endmodule

[design/bounded_array_list.sv]
// Bounded array list top level: configuration, sequencer, slot store, result register.
//
// An ordered list of signed 32-bit values in a slot RAM of DEPTH entries,
// with insert-at, remove-at, read-at and clear. The block takes one
// item at a time: ready is high only while the sequencer is idle. Because
// the RAM has one read and one write port with registered read data, each
// entry moved by an insert or remove takes a read state and a write state.
// An insert shifts entries from the tail down to the position up one slot,
// then writes the value; a remove shifts entries above it down, then fills
// the freed tail slot; a clear fills every slot, one slot per cycle. After
// reset a clearing pass fills the store with zero; no item is taken during
// it, configuration writes are.
module bounded_array_list #(
  parameter int DEPTH = bal_pkg::DEFAULT_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  bal_pkg::cfg_reg_t cfg_index,
  input  logic [31:0]       cfg_data,
  bal_chan_if.sink          req,
  bal_chan_if.source        rsp
);
  import bal_pkg::*;

  localparam int     AW        = $clog2(DEPTH);
  localparam int     CAP_MAX   = (DEPTH < (1 << CW) - 1) ? DEPTH : (1 << CW) - 1;
  localparam count_t CAP_MAX_C = count_t'(CAP_MAX);

  count_t  capacity;
  value_t  fill;
  count_t  cap_eff;

  logic    seq_rsp_valid;
  logic    rsp_take;
  rsp_t    seq_rsp;
  logic    out_valid;
  rsp_t    out_data;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  value_t        mem_wdata;
  logic [AW-1:0] mem_raddr;
  value_t        mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
      fill     <= FILL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CAPACITY: capacity <= cfg_data[CW-1:0];
        CFG_FILL:     fill     <= cfg_data;
      endcase
    end
  end

  // clamp capacity into one..min(DEPTH, 127)
  always_comb begin
    priority if (capacity == '0) begin
      cap_eff = count_t'(1);
    end else if (capacity > CAP_MAX_C) begin
      cap_eff = CAP_MAX_C;
    end else begin
      cap_eff = capacity;
    end
  end

  bal_seq #(.DEPTH(DEPTH)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_data  (req.data),
    .cap       (cap_eff),
    .fill      (fill),
    .rsp_valid (seq_rsp_valid),
    .rsp_take  (rsp_take),
    .rsp_data  (seq_rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  bal_slot_ram #(.DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rsp_take = seq_rsp_valid && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rsp_take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_take) begin
      out_data <= seq_rsp;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  a_no_take_while_pending: assert property (@(posedge clk) disable iff (rst)
    seq_rsp_valid |-> !req.ready)
    else $error("input taken while a result is still pending");

  a_busy_after_reset: assert property (@(posedge clk)
    rst |=> !req.ready)
    else $error("input ready during the post-reset clearing pass");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.entry_count <= CAP_MAX_C))
    else $error("entry count beyond the store size");

endmodule
